/* src/sdst_pkg.sv */
// Shared types, codes and constants of the saliency decay slot table.
`timescale 1ns / 1ps
package sdst_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);

  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [31:0] EXP_NEG1_Q32 = 32'd1580030169;
  localparam logic [3:0]  TAYLOR_LAST  = 4'd12;

  // Input actions.
  localparam logic [3:0] ACT_ADD    = 4'd0;
  localparam logic [3:0] ACT_ACCESS = 4'd1;
  localparam logic [3:0] ACT_REMOVE = 4'd2;
  localparam logic [3:0] ACT_FIND   = 4'd3;
  localparam logic [3:0] ACT_UPDATE = 4'd4;
  localparam logic [3:0] ACT_DECAY  = 4'd5;
  localparam logic [3:0] ACT_TOPK   = 4'd6;
  localparam logic [3:0] ACT_ABOVE  = 4'd7;
  localparam logic [3:0] ACT_STATS  = 4'd8;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_MISSING = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_DECAY_RATE = 2'd0;
  localparam logic [1:0] REG_DROP_THR   = 2'd1;
  localparam logic [1:0] REG_BOOST      = 2'd2;
  localparam logic [1:0] REG_SLOTS      = 2'd3;

  typedef enum logic [2:0] {
    C_IDLE, C_WORK, C_DWAIT, C_APPLY, C_TALLY, C_PICK, C_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    D_IDLE, D_X, D_MUL, D_DIV, D_FIX, D_POW, D_FIN
  } dec_state_t;

  // One decay request for a single slot.
  typedef struct packed {
    logic [15:0] rate;
    logic [31:0] dt;
    logic [16:0] base;
  } dec_req_t;

  // Rounded-up 2^34 / k for the Taylor term division, k from 1 to 12.
  function automatic logic [34:0] recip(input logic [3:0] k);
    logic [34:0] r;
    unique case (k)
      4'd1:    r = 35'd17179869184;
      4'd2:    r = 35'd8589934592;
      4'd3:    r = 35'd5726623062;
      4'd4:    r = 35'd4294967296;
      4'd5:    r = 35'd3435973837;
      4'd6:    r = 35'd2863311531;
      4'd7:    r = 35'd2454267027;
      4'd8:    r = 35'd2147483648;
      4'd9:    r = 35'd1908874354;
      4'd10:   r = 35'd1717986919;
      4'd11:   r = 35'd1561806290;
      4'd12:   r = 35'd1431655766;
      default: r = 35'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/sdst_decay.sv */
// Iterative exp decay unit: one shared multiplier stepped by a small sequencer.
`timescale 1ns / 1ps
module sdst_decay (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sdst_pkg::dec_req_t req,
  output logic              done,
  output logic [16:0]       cur
);

  sdst_pkg::dec_state_t st_r, st_nxt;

  logic [15:0] rate_r;
  logic [31:0] dt_r;
  logic [16:0] base_r;
  logic [31:0] f_r;
  logic [3:0]  whole_r;
  logic [32:0] term_r;
  logic [31:0] p_r;
  logic [32:0] q_r;
  logic [33:0] pos_r;
  logic [33:0] neg_r;
  logic [3:0]  k_r;
  logic [32:0] e_r;
  logic [3:0]  cnt_r;
  logic [16:0] cur_r;
  logic        done_r;

  logic [32:0] ma;
  logic [34:0] mb;
  logic [67:0] prod;
  logic        big;
  logic [32:0] qc;
  logic [33:0] pos_n;
  logic [33:0] neg_n;
  logic [67:0] rnd;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sdst_pkg::D_IDLE: if (start) st_nxt = sdst_pkg::D_X;
      sdst_pkg::D_X:    st_nxt = big ? sdst_pkg::D_FIN : sdst_pkg::D_MUL;
      sdst_pkg::D_MUL:  st_nxt = sdst_pkg::D_DIV;
      sdst_pkg::D_DIV:  st_nxt = sdst_pkg::D_FIX;
      sdst_pkg::D_FIX: begin
        st_nxt = (k_r == sdst_pkg::TAYLOR_LAST) ? sdst_pkg::D_POW : sdst_pkg::D_MUL;
      end
      sdst_pkg::D_POW:  if (cnt_r == whole_r) st_nxt = sdst_pkg::D_FIN;
      sdst_pkg::D_FIN:  st_nxt = sdst_pkg::D_IDLE;
      default:          st_nxt = sdst_pkg::D_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = 33'd0;
    mb = 35'd0;
    unique case (st_r)
      sdst_pkg::D_X: begin
        ma = {1'b0, dt_r};
        mb = {19'd0, rate_r};
      end
      sdst_pkg::D_MUL: begin
        ma = term_r;
        mb = {3'd0, f_r};
      end
      sdst_pkg::D_DIV: begin
        ma = {1'b0, p_r};
        mb = sdst_pkg::recip(k_r);
      end
      sdst_pkg::D_FIX: begin
        ma = q_r;
        mb = {31'd0, k_r};
      end
      sdst_pkg::D_POW: begin
        ma = e_r;
        mb = {3'd0, sdst_pkg::EXP_NEG1_Q32};
      end
      sdst_pkg::D_FIN: begin
        ma = e_r;
        mb = {18'd0, base_r};
      end
      default: begin
        ma = 33'd0;
        mb = 35'd0;
      end
    endcase
  end

  assign prod  = {35'd0, ma} * {33'd0, mb};
  assign big   = |prod[47:20];
  // The reciprocal estimate may be one too high; take it back if so.
  assign qc    = (prod > {36'd0, p_r}) ? (q_r - 33'd1) : q_r;
  assign pos_n = k_r[0] ? pos_r : (pos_r + {1'b0, qc});
  assign neg_n = k_r[0] ? (neg_r + {1'b0, qc}) : neg_r;
  assign rnd   = prod + 68'h0_8000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= sdst_pkg::D_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == sdst_pkg::D_FIN);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (st_r)
      sdst_pkg::D_IDLE: begin
        if (start) begin
          rate_r <= req.rate;
          dt_r   <= req.dt;
          base_r <= req.base;
        end
      end
      sdst_pkg::D_X: begin
        whole_r <= prod[19:16];
        f_r     <= {prod[15:0], 16'd0};
        term_r  <= {1'b1, 32'd0};
        pos_r   <= {2'b01, 32'd0};
        neg_r   <= 34'd0;
        k_r     <= 4'd1;
        cnt_r   <= 4'd0;
        if (big) e_r <= 33'd0;
      end
      sdst_pkg::D_MUL: p_r <= prod[63:32];
      sdst_pkg::D_DIV: q_r <= prod[66:34];
      sdst_pkg::D_FIX: begin
        term_r <= qc;
        pos_r  <= pos_n;
        neg_r  <= neg_n;
        k_r    <= k_r + 4'd1;
        if (k_r == sdst_pkg::TAYLOR_LAST) e_r <= pos_n[32:0] - neg_n[32:0];
      end
      sdst_pkg::D_POW: begin
        if (cnt_r != whole_r) begin
          e_r   <= prod[64:32];
          cnt_r <= cnt_r + 4'd1;
        end
      end
      sdst_pkg::D_FIN: cur_r <= rnd[48:32];
      default: ;
    endcase
  end

  assign done = done_r;
  assign cur  = cur_r;

endmodule

/* src/saliency_decay_slot_table.sv */
// Top level: slot table storage, action sequencer and result register.
//
//  Channel | Direction | Handshake             | Payload
//  in_     | input     | in_tvalid/in_tready   | in_tdata, in_tuser
//  out_    | output    | out_tvalid/out_tready | out_tdata, out_tuser, out_tlast
//  cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// One request is handled at a time; in_tready is high only while idle.
// Add, access, remove and find scan up to n live slots, act on at most one slot, then run a
// tally pass over the n live slots. Stats, clear, top-k and unused actions go straight to the tally.
// Decay and update run each valid slot through the shared decay unit, which takes a short
// path when the level decays straight to zero, and skip empty slots, then the tally.
// Top-k and above-threshold add one selection pass over the n slots per listed result.
// Reset is synchronous and empties the table; a stalled result holds the sequencer.
`timescale 1ns / 1ps
module saliency_decay_slot_table (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // item_id[63:0], new_saliency[80:64], now_ticks[112:81], result_limit[117:113],
  // query_threshold[134:118], zero pad
  input  logic [135:0] in_tdata,
  // action[3:0], clear_request[4]
  input  logic [4:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_id[63:0], result_saliency[80:64], slot_pos[84:81], evicted[85],
  // evicted_id[149:86], active_slots[154:150], level_sum[175:155],
  // level_min[192:176], level_max[209:193], zero pad
  output logic [215:0] out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_wdata
);

  localparam int SW = sdst_pkg::SLOT_W;

  sdst_pkg::ctl_state_t st_r, st_nxt;

  // Configuration.
  logic [15:0] rate_r;
  logic [16:0] drop_r;
  logic [16:0] boost_r;
  logic [4:0]  siu_r;

  // Latched request.
  logic [3:0]  act_r;
  logic [63:0] id_r;
  logic [16:0] ns_r;
  logic [31:0] now_r;
  logic [4:0]  lim_r;
  logic [16:0] qt_r;

  // Slot storage.
  logic [sdst_pkg::SLOTS-1:0] valid_r;
  logic [63:0] key_r   [sdst_pkg::SLOTS];
  logic [16:0] base_r  [sdst_pkg::SLOTS];
  logic [16:0] cur_r   [sdst_pkg::SLOTS];
  logic [31:0] touch_r [sdst_pkg::SLOTS];

  // Sequencer working registers.
  logic [SW-1:0] ptr_r;
  logic [SW-1:0] best_r;
  logic [16:0]   low_r;
  logic          found_r;
  logic [1:0]    res_status_r;
  logic [63:0]   res_id_r;
  logic [16:0]   res_sal_r;
  logic [SW-1:0] res_idx_r;
  logic          res_ev_r;
  logic [63:0]   res_evid_r;
  logic [4:0]    cnt_r;
  logic [20:0]   tot_r;
  logic [16:0]   min_r;
  logic [16:0]   max_r;
  logic [sdst_pkg::SLOTS-1:0] cand_r;
  logic [4:0]    hcnt_r;
  logic [4:0]    want_r;
  logic [4:0]    rnum_r;
  logic [16:0]   pval_r;
  logic          pfound_r;
  logic          empty_r;

  // Result register.
  logic         out_valid_r;
  logic [215:0] out_data_r;
  logic [1:0]   out_user_r;
  logic         out_last_r;

  // Decay unit link.
  sdst_pkg::dec_req_t dec_req;
  logic        dec_start;
  logic        dec_done;
  logic [16:0] dec_cur;

  logic          accept;
  logic          out_free;
  logic          push;
  logic [4:0]    live;
  logic [SW-1:0] last_idx;
  logic          scan_end;
  logic          val_p;
  logic [63:0]   key_p;
  logic [16:0]   cur_p;
  logic [16:0]   base_p;
  logic [3:0]    a_in;
  logic          list_mode;
  logic          is_last;
  logic          hit_free;
  logic          hit_low;
  logic          hit_id;
  logic          take;
  logic [4:0]    cnt_fin;
  logic [4:0]    want_calc;
  logic [17:0]   boost_sum;
  logic [16:0]   boosted;
  logic [16:0]   ns_in;
  logic [4:0]    lim_in;

  // Result fields driven while in the output state.
  logic [1:0]    o_status;
  logic [63:0]   o_id;
  logic [16:0]   o_sal;
  logic [SW-1:0] o_idx;
  logic          o_ev;
  logic [63:0]   o_evid;
  logic [16:0]   o_min;
  logic [16:0]   o_max;
  logic          o_last;

  // Live slot count and scan position.
  always_comb begin
    if (siu_r == 5'd0) live = 5'd1;
    else if (siu_r > 5'(sdst_pkg::SLOTS)) live = 5'(sdst_pkg::SLOTS);
    else live = siu_r;
  end
  assign last_idx = SW'(live - 5'd1);
  assign scan_end = (ptr_r == last_idx);

  assign val_p  = valid_r[ptr_r];
  assign key_p  = key_r[ptr_r];
  assign cur_p  = cur_r[ptr_r];
  assign base_p = base_r[ptr_r];

  assign a_in      = in_tuser[3:0];
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign list_mode = (act_r == sdst_pkg::ACT_TOPK) || (act_r == sdst_pkg::ACT_ABOVE);
  assign is_last   = ((rnum_r + 5'd1) == want_r);

  assign hit_free = !val_p;
  assign hit_low  = val_p && (cur_p < low_r);
  assign hit_id   = val_p && (key_p == id_r);
  assign take     = cand_r[ptr_r] &&
                    (!pfound_r || ((act_r == sdst_pkg::ACT_TOPK) && (cur_p > pval_r)));

  assign cnt_fin = cnt_r + {4'd0, val_p};
  always_comb begin
    if (act_r == sdst_pkg::ACT_TOPK) want_calc = (lim_r < cnt_fin) ? lim_r : cnt_fin;
    else want_calc = hcnt_r;
  end

  assign boost_sum = {1'b0, base_p} + {1'b0, boost_r};
  assign boosted   = (boost_sum > {1'b0, sdst_pkg::ONE_Q16}) ? sdst_pkg::ONE_Q16
                                                             : boost_sum[16:0];
  assign ns_in  = (in_tdata[80:64] > sdst_pkg::ONE_Q16) ? sdst_pkg::ONE_Q16 : in_tdata[80:64];
  assign lim_in = (in_tdata[117:113] > 5'd16) ? 5'd16 : in_tdata[117:113];

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sdst_pkg::C_IDLE: begin
        if (accept) begin
          if (a_in == sdst_pkg::ACT_TOPK || a_in > sdst_pkg::ACT_ABOVE) st_nxt = sdst_pkg::C_TALLY;
          else st_nxt = sdst_pkg::C_WORK;
        end
      end
      sdst_pkg::C_WORK: begin
        priority case (act_r)
          sdst_pkg::ACT_ADD: if (hit_free || scan_end) st_nxt = sdst_pkg::C_APPLY;
          sdst_pkg::ACT_ACCESS, sdst_pkg::ACT_REMOVE, sdst_pkg::ACT_FIND: begin
            if (hit_id || scan_end) st_nxt = sdst_pkg::C_APPLY;
          end
          sdst_pkg::ACT_UPDATE, sdst_pkg::ACT_DECAY: begin
            if (val_p) st_nxt = sdst_pkg::C_DWAIT;
            else if (scan_end) st_nxt = sdst_pkg::C_TALLY;
          end
          default: if (scan_end) st_nxt = sdst_pkg::C_TALLY;
        endcase
      end
      sdst_pkg::C_DWAIT: begin
        if (dec_done) st_nxt = scan_end ? sdst_pkg::C_TALLY : sdst_pkg::C_WORK;
      end
      sdst_pkg::C_APPLY: st_nxt = sdst_pkg::C_TALLY;
      sdst_pkg::C_TALLY: begin
        if (scan_end) begin
          if (list_mode && want_calc != 5'd0) st_nxt = sdst_pkg::C_PICK;
          else st_nxt = sdst_pkg::C_OUT;
        end
      end
      sdst_pkg::C_PICK: if (scan_end) st_nxt = sdst_pkg::C_OUT;
      sdst_pkg::C_OUT: begin
        if (push) begin
          st_nxt = (list_mode && !empty_r && !is_last) ? sdst_pkg::C_PICK : sdst_pkg::C_IDLE;
        end
      end
      default: st_nxt = sdst_pkg::C_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = (st_r == sdst_pkg::C_IDLE);
    push      = (st_r == sdst_pkg::C_OUT) && out_free;
    dec_start = (st_r == sdst_pkg::C_WORK) && val_p &&
                (act_r == sdst_pkg::ACT_UPDATE || act_r == sdst_pkg::ACT_DECAY);
    o_status = res_status_r;
    o_id     = res_id_r;
    o_sal    = res_sal_r;
    o_idx    = res_idx_r;
    o_ev     = res_ev_r;
    o_evid   = res_evid_r;
    o_min    = (act_r == sdst_pkg::ACT_STATS) ? min_r : 17'd0;
    o_max    = (act_r == sdst_pkg::ACT_STATS) ? max_r : 17'd0;
    o_last   = 1'b1;
    if (list_mode) begin
      o_ev   = 1'b0;
      o_evid = 64'd0;
      if (empty_r) begin
        o_status = sdst_pkg::STAT_EMPTY;
        o_id     = 64'd0;
        o_sal    = 17'd0;
        o_idx    = '0;
      end else begin
        o_status = sdst_pkg::STAT_OK;
        o_id     = key_p;
        o_sal    = cur_p;
        o_idx    = ptr_r;
        o_last   = is_last;
      end
    end
  end

  assign dec_req.rate = rate_r;
  assign dec_req.dt   = now_r - touch_r[ptr_r];
  assign dec_req.base = base_p;

  sdst_decay u_decay (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dec_start),
    .req   (dec_req),
    .done  (dec_done),
    .cur   (dec_cur)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= sdst_pkg::C_IDLE;
      out_valid_r <= 1'b0;
      rate_r      <= 16'd655;
      drop_r      <= 17'd6554;
      boost_r     <= 17'd6554;
      siu_r       <= 5'd16;
    end else begin
      st_r <= st_nxt;
      if (push) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          sdst_pkg::REG_DECAY_RATE: rate_r  <= cfg_wdata[15:0];
          sdst_pkg::REG_DROP_THR:   drop_r  <= cfg_wdata;
          sdst_pkg::REG_BOOST:      boost_r <= cfg_wdata;
          sdst_pkg::REG_SLOTS:      siu_r   <= cfg_wdata[4:0];
          default: ;
        endcase
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      unique case (st_r)
        sdst_pkg::C_IDLE: begin
          if (accept && a_in == sdst_pkg::ACT_STATS && in_tuser[4]) valid_r <= '0;
        end
        sdst_pkg::C_DWAIT: begin
          if (dec_done && act_r == sdst_pkg::ACT_UPDATE && dec_cur < drop_r) begin
            valid_r[ptr_r] <= 1'b0;
          end
        end
        sdst_pkg::C_APPLY: begin
          if (found_r) begin
            if (act_r == sdst_pkg::ACT_ADD) valid_r[ptr_r] <= 1'b1;
            else if (act_r == sdst_pkg::ACT_REMOVE) valid_r[ptr_r] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer datapath and slot contents.
  always_ff @(posedge clk) begin
    unique case (st_r)
      sdst_pkg::C_IDLE: begin
        if (accept) begin
          act_r        <= a_in;
          id_r         <= in_tdata[63:0];
          ns_r         <= ns_in;
          now_r        <= in_tdata[112:81];
          lim_r        <= lim_in;
          qt_r         <= in_tdata[134:118];
          ptr_r        <= '0;
          best_r       <= '0;
          low_r        <= sdst_pkg::ONE_Q16;
          found_r      <= 1'b0;
          res_status_r <= sdst_pkg::STAT_OK;
          res_id_r     <= 64'd0;
          res_sal_r    <= 17'd0;
          res_idx_r    <= '0;
          res_ev_r     <= 1'b0;
          res_evid_r   <= 64'd0;
          cnt_r        <= 5'd0;
          tot_r        <= 21'd0;
          min_r        <= sdst_pkg::ONE_Q16;
          max_r        <= 17'd0;
          cand_r       <= '0;
          hcnt_r       <= 5'd0;
          rnum_r       <= 5'd0;
          pfound_r     <= 1'b0;
          empty_r      <= 1'b0;
        end
      end
      sdst_pkg::C_WORK: begin
        priority case (act_r)
          sdst_pkg::ACT_ADD: begin
            // First empty slot wins; else the lowest level below one.
            if (hit_low) begin
              low_r  <= cur_p;
              best_r <= ptr_r;
            end
            found_r <= found_r || hit_free || hit_low;
            if (hit_free || scan_end) begin
              if (!(hit_free || hit_low)) ptr_r <= best_r;
            end else begin
              ptr_r <= ptr_r + SW'(1);
            end
          end
          sdst_pkg::ACT_ACCESS, sdst_pkg::ACT_REMOVE, sdst_pkg::ACT_FIND: begin
            if (hit_id) found_r <= 1'b1;
            else if (!scan_end) ptr_r <= ptr_r + SW'(1);
          end
          sdst_pkg::ACT_UPDATE, sdst_pkg::ACT_DECAY: begin
            if (!val_p) ptr_r <= scan_end ? '0 : ptr_r + SW'(1);
          end
          default: begin
            // Above-threshold hits are kept in order, up to the limit.
            if (val_p && cur_p >= qt_r && hcnt_r < lim_r) begin
              cand_r[ptr_r] <= 1'b1;
              hcnt_r        <= hcnt_r + 5'd1;
            end
            ptr_r <= scan_end ? '0 : ptr_r + SW'(1);
          end
        endcase
      end
      sdst_pkg::C_DWAIT: begin
        if (dec_done) begin
          cur_r[ptr_r] <= dec_cur;
          ptr_r        <= scan_end ? '0 : ptr_r + SW'(1);
        end
      end
      sdst_pkg::C_APPLY: begin
        res_id_r <= id_r;
        ptr_r    <= '0;
        if (!found_r) begin
          res_status_r <= (act_r == sdst_pkg::ACT_ADD) ? sdst_pkg::STAT_FULL
                                                       : sdst_pkg::STAT_MISSING;
        end else begin
          res_idx_r <= ptr_r;
          if (act_r == sdst_pkg::ACT_ADD) begin
            res_ev_r        <= val_p;
            res_evid_r      <= val_p ? key_p : 64'd0;
            res_sal_r       <= ns_r;
            key_r[ptr_r]    <= id_r;
            base_r[ptr_r]   <= ns_r;
            cur_r[ptr_r]    <= ns_r;
            touch_r[ptr_r]  <= now_r;
          end else if (act_r == sdst_pkg::ACT_ACCESS) begin
            res_sal_r       <= boosted;
            base_r[ptr_r]   <= boosted;
            cur_r[ptr_r]    <= boosted;
            touch_r[ptr_r]  <= now_r;
          end else begin
            res_sal_r <= cur_p;
          end
        end
      end
      sdst_pkg::C_TALLY: begin
        if (val_p) begin
          cnt_r <= cnt_r + 5'd1;
          tot_r <= tot_r + {4'd0, cur_p};
          if (cur_p < min_r) min_r <= cur_p;
          if (cur_p > max_r) max_r <= cur_p;
        end
        if (act_r == sdst_pkg::ACT_TOPK) cand_r[ptr_r] <= val_p;
        if (scan_end) begin
          want_r   <= want_calc;
          empty_r  <= (want_calc == 5'd0);
          ptr_r    <= '0;
          pfound_r <= 1'b0;
        end else begin
          ptr_r <= ptr_r + SW'(1);
        end
      end
      sdst_pkg::C_PICK: begin
        // Strictly greater keeps the lower slot on equal levels.
        if (take) begin
          best_r   <= ptr_r;
          pval_r   <= cur_p;
          pfound_r <= 1'b1;
        end
        if (scan_end) begin
          if (!take) ptr_r <= best_r;
        end else begin
          ptr_r <= ptr_r + SW'(1);
        end
      end
      sdst_pkg::C_OUT: begin
        if (push && list_mode && !empty_r) begin
          cand_r[ptr_r] <= 1'b0;
          rnum_r        <= rnum_r + 5'd1;
          ptr_r         <= '0;
          pfound_r      <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (push) begin
      out_user_r <= o_status;
      out_last_r <= o_last;
      out_data_r <= {6'd0, o_max, o_min, tot_r, cnt_r, o_evid, o_ev,
                     4'(o_idx), o_sal, o_id};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // The decay unit only answers while the sequencer waits for it.
  a_dec_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dec_done |-> st_r == sdst_pkg::C_DWAIT)
    else $error("decay result outside of a decay wait");

  // No new request is taken right after one was accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("request accepted while busy");

  // The final result of a request returns the sequencer to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push && o_last) |=> st_r == sdst_pkg::C_IDLE)
    else $error("sequencer did not finish after the final result");

  // A list never emits more results than it planned.
  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == sdst_pkg::C_PICK) |-> rnum_r < want_r)
    else $error("list ran past its result count");

endmodule

/* verif/tb_saliency_decay_slot_table.sv */
// Self-checking testbench for the saliency decay slot table with a built-in predictor.
`timescale 1ns / 1ps
module tb_saliency_decay_slot_table;

  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [3:0]  action;
    logic        clr;
    logic [63:0] id;
    logic [16:0] sal;
    logic [31:0] now;
    logic [4:0]  lim;
    logic [16:0] qt;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] id;
    logic [16:0] sal;
    logic [3:0]  idx;
    logic        ev;
    logic [63:0] evid;
    logic [4:0]  cnt;
    logic [20:0] tot;
    logic [16:0] mn;
    logic [16:0] mx;
    logic        last;
  } rsp_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic [4:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [215:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [16:0]  cfg_wdata = '0;

  saliency_decay_slot_table u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic        m_valid [sdst_pkg::SLOTS];
  logic [63:0] m_key [sdst_pkg::SLOTS];
  logic [16:0] m_base [sdst_pkg::SLOTS];
  logic [16:0] m_cur [sdst_pkg::SLOTS];
  logic [31:0] m_touch [sdst_pkg::SLOTS];
  logic [15:0] m_rate;
  logic [16:0] m_drop;
  logic [16:0] m_boost;
  logic [4:0]  m_slots;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles = 0;

  function automatic int live_count();
    if (m_slots < 1) return 1;
    if (m_slots > sdst_pkg::SLOTS) return sdst_pkg::SLOTS;
    return int'(m_slots);
  endfunction

  function automatic logic [63:0] exp_neg_q32(logic [63:0] x);
    logic [63:0] whole, f, term, pos, neg, r;
    whole = x >> 16;
    f = (x & 64'hFFFF) << 16;
    term = 64'd1 << 32;
    pos = term;
    neg = 0;
    if (whole >= 16) return 0;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * f) >> 32) / k;
      if (k % 2) neg += term;
      else pos += term;
    end
    r = pos - neg;
    for (int i = 0; i < whole; i++) r = (r * 64'd1580030169) >> 32;
    return r;
  endfunction

  // Builds one result; count and total reflect the table after the action.
  function automatic rsp_t make_rsp(logic [1:0] st, logic [63:0] id, logic [16:0] sal,
                                    logic [3:0] idx, logic ev, logic [63:0] evid,
                                    logic [16:0] mn, logic [16:0] mx, logic last);
    rsp_t r;
    int c, s;
    c = 0;
    s = 0;
    for (int i = 0; i < live_count(); i++)
      if (m_valid[i]) begin
        c++;
        s += m_cur[i];
      end
    if (s > 2097151) s = 2097151;
    r.status = st; r.id = id; r.sal = sal; r.idx = idx; r.ev = ev; r.evid = evid;
    r.cnt = c[4:0]; r.tot = s[20:0]; r.mn = mn; r.mx = mx; r.last = last;
    return r;
  endfunction

  // Applies one request to the predictor and queues its results.
  task automatic predict_table(req_t q);
    int n, best, k, want, avail, h;
    logic [16:0] ns, low;
    logic [4:0] lim;
    logic [63:0] dt, e;
    logic [17:0] b;
    logic taken [sdst_pkg::SLOTS];
    int hits [sdst_pkg::SLOTS];
    logic [16:0] mn, mx;
    n = live_count();
    ns = (q.sal > sdst_pkg::ONE_Q16) ? sdst_pkg::ONE_Q16 : q.sal;
    lim = (q.lim > 16) ? 5'd16 : q.lim;
    k = 0;
    case (q.action)
      sdst_pkg::ACT_ADD: begin
        best = -1;
        low = sdst_pkg::ONE_Q16;
        for (int i = 0; i < n; i++) begin
          if (!m_valid[i]) begin
            best = i;
            break;
          end
          if (m_cur[i] < low) begin
            low = m_cur[i];
            best = i;
          end
        end
        if (best < 0) begin
          expected_rsps.push_back(make_rsp(sdst_pkg::STAT_FULL, q.id, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          logic ev;
          logic [63:0] evid;
          ev = m_valid[best];
          evid = ev ? m_key[best] : 64'd0;
          m_valid[best] = 1; m_key[best] = q.id; m_base[best] = ns;
          m_cur[best] = ns; m_touch[best] = q.now;
          expected_rsps.push_back(make_rsp(sdst_pkg::STAT_OK, q.id, ns, best[3:0], ev, evid,
                                           0, 0, 1));
        end
      end
      sdst_pkg::ACT_ACCESS, sdst_pkg::ACT_REMOVE, sdst_pkg::ACT_FIND: begin
        best = -1;
        for (int i = 0; i < n; i++)
          if (best < 0 && m_valid[i] && m_key[i] == q.id) best = i;
        if (best < 0) begin
          expected_rsps.push_back(make_rsp(sdst_pkg::STAT_MISSING, q.id, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          logic [16:0] sal;
          if (q.action == sdst_pkg::ACT_ACCESS) begin
            b = m_base[best] + m_boost;
            if (b > sdst_pkg::ONE_Q16) b = sdst_pkg::ONE_Q16;
            m_base[best] = b[16:0]; m_cur[best] = b[16:0]; m_touch[best] = q.now;
          end
          sal = m_cur[best];
          if (q.action == sdst_pkg::ACT_REMOVE) m_valid[best] = 0;
          expected_rsps.push_back(make_rsp(sdst_pkg::STAT_OK, q.id, sal, best[3:0],
                                           0, 0, 0, 0, 1));
        end
      end
      sdst_pkg::ACT_UPDATE, sdst_pkg::ACT_DECAY: begin
        for (int i = 0; i < n; i++)
          if (m_valid[i]) begin
            dt = {32'd0, q.now - m_touch[i]};
            e = exp_neg_q32({48'd0, m_rate} * dt);
            m_cur[i] = 17'(({47'd0, m_base[i]} * e + (64'd1 << 31)) >> 32);
          end
        if (q.action == sdst_pkg::ACT_UPDATE)
          for (int i = 0; i < n; i++)
            if (m_valid[i] && m_cur[i] < m_drop) m_valid[i] = 0;
        expected_rsps.push_back(make_rsp(sdst_pkg::STAT_OK, 0, 0, 0, 0, 0, 0, 0, 1));
      end
      sdst_pkg::ACT_TOPK: begin
        avail = 0;
        for (int i = 0; i < sdst_pkg::SLOTS; i++) taken[i] = 0;
        for (int i = 0; i < n; i++) if (m_valid[i]) avail++;
        want = (lim < avail) ? lim : avail;
        for (int r = 0; r < want; r++) begin
          best = -1;
          for (int i = 0; i < n; i++)
            if (m_valid[i] && !taken[i] && (best < 0 || m_cur[i] > m_cur[best])) best = i;
          taken[best] = 1;
          expected_rsps.push_back(make_rsp(sdst_pkg::STAT_OK, m_key[best], m_cur[best],
                                           best[3:0], 0, 0, 0, 0, r + 1 == want));
          k++;
        end
        if (k == 0)
          expected_rsps.push_back(make_rsp(sdst_pkg::STAT_EMPTY, 0, 0, 0, 0, 0, 0, 0, 1));
      end
      sdst_pkg::ACT_ABOVE: begin
        h = 0;
        for (int i = 0; i < n && h < lim; i++)
          if (m_valid[i] && m_cur[i] >= q.qt) hits[h++] = i;
        for (int j = 0; j < h; j++)
          expected_rsps.push_back(make_rsp(sdst_pkg::STAT_OK, m_key[hits[j]], m_cur[hits[j]],
                                           hits[j][3:0], 0, 0, 0, 0, j + 1 == h));
        if (h == 0)
          expected_rsps.push_back(make_rsp(sdst_pkg::STAT_EMPTY, 0, 0, 0, 0, 0, 0, 0, 1));
      end
      sdst_pkg::ACT_STATS: begin
        mn = sdst_pkg::ONE_Q16;
        mx = 0;
        if (q.clr) begin
          for (int i = 0; i < sdst_pkg::SLOTS; i++) m_valid[i] = 0;
        end else begin
          for (int i = 0; i < n; i++)
            if (m_valid[i]) begin
              if (m_cur[i] > mx) mx = m_cur[i];
              if (m_cur[i] < mn) mn = m_cur[i];
            end
        end
        expected_rsps.push_back(make_rsp(sdst_pkg::STAT_OK, 0, 0, 0, 0, 0, mn, mx, 1));
      end
      default: begin
        expected_rsps.push_back(make_rsp(sdst_pkg::STAT_OK, 0, 0, 0, 0, 0, 0, 0, 1));
      end
    endcase
  endtask

  // Driver: presents queued requests, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_table(pending_reqs.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {1'b0, pending_reqs[0].qt, pending_reqs[0].lim, pending_reqs[0].now,
                       pending_reqs[0].sal, pending_reqs[0].id};
          in_tuser <= {pending_reqs[0].clr, pending_reqs[0].action};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    rsp_t got, want;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[63:0], out_tdata[80:64], out_tdata[84:81],
               out_tdata[85], out_tdata[149:86], out_tdata[154:150], out_tdata[175:155],
               out_tdata[192:176], out_tdata[209:193], out_tlast};
        if (expected_rsps.size() == 0) begin
          $error("unexpected result: status %0d id %h", got.status, got.id);
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); errors++;
          end
          if (got.id !== want.id) begin
            $error("result_id exp %h got %h", want.id, got.id); errors++;
          end
          if (got.sal !== want.sal) begin
            $error("result_saliency exp %0d got %0d", want.sal, got.sal); errors++;
          end
          if (got.idx !== want.idx) begin
            $error("slot_pos exp %0d got %0d", want.idx, got.idx); errors++;
          end
          if (got.ev !== want.ev) begin
            $error("evicted exp %0d got %0d", want.ev, got.ev); errors++;
          end
          if (got.evid !== want.evid) begin
            $error("evicted_id exp %h got %h", want.evid, got.evid); errors++;
          end
          if (got.cnt !== want.cnt) begin
            $error("active_slots exp %0d got %0d", want.cnt, got.cnt); errors++;
          end
          if (got.tot !== want.tot) begin
            $error("level_sum exp %0d got %0d", want.tot, got.tot); errors++;
          end
          if (got.mn !== want.mn) begin
            $error("level_min exp %0d got %0d", want.mn, got.mn); errors++;
          end
          if (got.mx !== want.mx) begin
            $error("level_max exp %0d got %0d", want.mx, got.mx); errors++;
          end
          if (got.last !== want.last) begin
            $error("last exp %0d got %0d", want.last, got.last); errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("saliency_decay_slot_table regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand_id();
    return {$urandom(), $urandom()};
  endfunction

  function automatic req_t make_req(logic [3:0] act, logic [63:0] id, logic [16:0] sal,
                                    logic [31:0] now);
    req_t q;
    q.action = act;
    q.clr = 1'($urandom_range(1));
    q.id = id;
    q.sal = sal;
    q.now = now;
    q.lim = 5'($urandom_range(31));
    q.qt = 17'($urandom_range(65536));
    return q;
  endfunction

  task automatic drain_all();
    while (pending_reqs.size() != 0 || in_tvalid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // A config write happens only while the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sdst_pkg::REG_DECAY_RATE: m_rate = val[15:0];
      sdst_pkg::REG_DROP_THR:   m_drop = val;
      sdst_pkg::REG_BOOST:      m_boost = val;
      default:                  m_slots = val[4:0];
    endcase
  endtask

  // Random phase: mostly adds and queries on a pool of eight ids.
  task automatic random_phase(int count, int idle, int stall, inout logic [31:0] clock_now);
    logic [63:0] ids [8];
    req_t q;
    for (int i = 0; i < 8; i++) ids[i] = rand_id();
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      int r;
      r = $urandom_range(99);
      clock_now += $urandom_range(3) == 0 ? $urandom() : $urandom_range(200);
      if (r < 30) q = make_req(sdst_pkg::ACT_ADD, ids[$urandom_range(7)],
                               $urandom_range(3) == 0 ? 17'($urandom()) :
                               17'($urandom_range(65536)), clock_now);
      else if (r < 90) q = make_req(4'($urandom_range(1, 8)),
                                    $urandom_range(4) == 0 ? rand_id() : ids[$urandom_range(7)],
                                    17'($urandom()), clock_now);
      else q = make_req(4'($urandom_range(15)), rand_id(), 17'($urandom()), clock_now);
      if (q.action == sdst_pkg::ACT_STATS && $urandom_range(3) != 0) q.clr = 0;
      pending_reqs.push_back(q);
    end
    drain_all();
  endtask

  initial begin
    logic [31:0] t;
    m_rate = 655; m_drop = 6554; m_boost = 6554; m_slots = 16;
    for (int i = 0; i < sdst_pkg::SLOTS; i++) begin
      m_valid[i] = 0; m_key[i] = 0; m_base[i] = 0; m_cur[i] = 0; m_touch[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty lists, fill past capacity, extremes, every action.
    t = 0;
    pending_reqs.push_back(make_req(sdst_pkg::ACT_TOPK, 0, 0, t));
    pending_reqs.push_back(make_req(sdst_pkg::ACT_ABOVE, 0, 0, t));
    pending_reqs.push_back(make_req(sdst_pkg::ACT_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 0, t));
    for (int i = 0; i < 17; i++)
      pending_reqs.push_back(make_req(sdst_pkg::ACT_ADD,
                                      i == 0 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(i),
                                      i == 1 ? 17'h1FFFF : 17'(i * 4000), t));
    pending_reqs.push_back(make_req(sdst_pkg::ACT_ACCESS, 64'd2, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(sdst_pkg::ACT_DECAY, 0, 0, 32'd100));
    pending_reqs.push_back(make_req(sdst_pkg::ACT_UPDATE, 0, 0, 32'd5000));
    pending_reqs.push_back(make_req(sdst_pkg::ACT_REMOVE, 64'd3, 0, t));
    pending_reqs.push_back(make_req(4'd15, 0, 0, t));
    pending_reqs.push_back(make_req(sdst_pkg::ACT_STATS, 0, 0, t));
    pending_reqs[$].clr = 0;
    drain_all();

    // Random phases across idling patterns and register settings.
    t = 32'd10000;
    random_phase(45, 0, 0, t);
    write_reg(sdst_pkg::REG_DECAY_RATE, 17'd65535);
    write_reg(sdst_pkg::REG_DROP_THR, 17'd65536);
    write_reg(sdst_pkg::REG_BOOST, 17'd65536);
    write_reg(sdst_pkg::REG_SLOTS, 17'd1);
    random_phase(40, 67, 0, t);
    write_reg(sdst_pkg::REG_DECAY_RATE, 17'd0);
    write_reg(sdst_pkg::REG_DROP_THR, 17'd0);
    write_reg(sdst_pkg::REG_BOOST, 17'd0);
    write_reg(sdst_pkg::REG_SLOTS, 17'd0);
    random_phase(40, 0, 67, t);
    write_reg(sdst_pkg::REG_DECAY_RATE, 17'd20);
    write_reg(sdst_pkg::REG_DROP_THR, 17'd3000);
    write_reg(sdst_pkg::REG_BOOST, 17'd30000);
    write_reg(sdst_pkg::REG_SLOTS, 17'd31);
    random_phase(40, 23, 23, t);
    write_reg(sdst_pkg::REG_SLOTS, 17'd5);
    write_reg(sdst_pkg::REG_DECAY_RATE, 17'd655);
    random_phase(40, 10, 10, t);

    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("saliency_decay_slot_table regression: pass");
    end else begin
      $display("saliency_decay_slot_table regression: fail");
    end
    $finish;
  end

endmodule
